### design/sobel_gradient_magnitude_macros.svh
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: assertion macros
// Concurrent assertion forms used by sobel_gradient_magnitude.sv.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sgm_pkg.sv
// ----------------------------------------------------------------------------
// Sobel gradient magnitude package
// Field widths, register map, reset values and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

  // Field widths of the input and result items.
  localparam int unsigned PixW   = 8;
  localparam int unsigned GradW  = 11;
  localparam int unsigned MagW   = 11;
  localparam int unsigned FwW    = 11;
  localparam int unsigned FhW    = 13;
  localparam int unsigned RowW   = 12;
  localparam int unsigned OutW   = 48;

  // Largest supported frame height.
  localparam int unsigned HeightMax = 4096;

  // Square root: radicand width and number of digit steps.
  localparam int unsigned RadW      = 22;
  localparam int unsigned RemW      = 12;
  localparam int unsigned RootSteps = 11;
  localparam int unsigned StepW     = 4;

  // Configuration port.
  localparam int unsigned ApbAw = 3;
  localparam int unsigned ApbDw = 32;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } sgm_reg_e;

  localparam logic [FwW-1:0] FwReset = 11'd640;
  localparam logic [FhW-1:0] FhReset = 13'd480;

  // Per-pixel sequencer.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_LOAD
  } sgm_state_e;

endpackage

`default_nettype wire

### design/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// Sobel gradient magnitude
// Streaming 3x3 Sobel edge filter over 8-bit grey pixels in raster order.
// Input: one pixel per s_axis transfer. Output: one result per pixel on m_axis
// with grad_x, grad_y, magnitude and the running frame peak in tdata, the
// interior flag in tuser and the last-of-frame mark in tlast. The result for a
// pixel belongs to the window centered one row and one column back; border
// positions give zero gradients. Frame size is set over the APB port; the
// user is to write it only while the block is idle, which the block itself
// does not enforce. After reset the block clears its line store, one column
// per cycle, before s_axis_tready rises. Each pixel runs through a line store
// read, a window and gradient step, a squaring step, the digit-by-digit square
// root and an output load before the next transfer is accepted. The output
// register lets the next pixel be accepted while a result waits; a stalled
// receiver holds the sequencer in its load step once a second result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sobel_gradient_magnitude_macros.svh"

module sobel_gradient_magnitude #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Pixel stream.
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [7:0]                  s_axis_tdata_i,  // [7:0] pixel
  // Result stream.
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // [10:0] grad_x, [21:11] grad_y, [32:22] magnitude, [43:33] frame_peak
  output logic [sgm_pkg::OutW-1:0]         m_axis_tdata_o,
  output logic                             m_axis_tuser_o,  // [0] interior
  output logic                             m_axis_tlast_o,  // frame_last
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sgm_pkg::ApbAw-1:0]   paddr,
  input  wire logic [sgm_pkg::ApbDw-1:0]   pwdata,
  output logic      [sgm_pkg::ApbDw-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW + 1 > sgm_pkg::FwW) ? CW + 1 : sgm_pkg::FwW;
  localparam int unsigned PW = sgm_pkg::PixW;

  // Registers.
  sgm_pkg::sgm_state_e              state_q, state_d;
  logic [sgm_pkg::FwW-1:0]          fw_q;
  logic [sgm_pkg::FhW-1:0]          fh_q;
  logic [CW-1:0]                    clr_q, clr_d;
  logic [CW-1:0]                    col_q, col_d;
  logic [sgm_pkg::RowW-1:0]         row_q, row_d;
  logic [PW-1:0]                    win_q [6];
  logic [PW-1:0]                    win_d [6];
  logic [sgm_pkg::MagW-1:0]         peak_q, peak_d;
  logic [sgm_pkg::StepW-1:0]        step_q, step_d;
  logic                             out_valid_q, out_valid_d;

  logic [PW-1:0]                    pix_q, pix_d;
  logic signed [sgm_pkg::GradW-1:0] gx_q, gx_d, gy_q, gy_d;
  logic                             interior_q, interior_d;
  logic                             last_q, last_d;
  logic [sgm_pkg::RadW-1:0]         rad_q, rad_d;
  logic [sgm_pkg::RemW-1:0]         rem_q, rem_d;
  logic [sgm_pkg::MagW-1:0]         root_q, root_d;
  logic signed [sgm_pkg::GradW-1:0] out_gx_q, out_gx_d, out_gy_q, out_gy_d;
  logic [sgm_pkg::MagW-1:0]         out_mag_q, out_mag_d;
  logic [sgm_pkg::MagW-1:0]         out_peak_q, out_peak_d;
  logic                             out_interior_q, out_interior_d;
  logic                             out_last_q, out_last_d;

  // Line store port signals: upper row in the high byte, middle row low.
  logic                             ram_we, ram_re;
  logic [CW-1:0]                    ram_waddr;
  logic [2*PW-1:0]                  ram_wdata, ram_rdata;

  // Combinational helpers.
  logic                             s_xfer, m_xfer, cfg_wr, load;
  logic [PW-1:0]                    up_pix, mid_pix;
  logic [PW+1:0]                    gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [sgm_pkg::GradW-1:0] gx_win, gy_win;
  logic [WW-1:0]                    col_nx;
  logic [sgm_pkg::FhW-1:0]          row_nx;
  logic                             wrap_col, wrap_row;
  logic signed [sgm_pkg::RadW-1:0]  gx_ext, gy_ext;
  logic [sgm_pkg::RemW+1:0]         rem_sh, trial, diff;
  logic                             fits;
  logic [sgm_pkg::MagW-1:0]         peak_new;

  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign m_xfer = out_valid_q && m_axis_tready_i;
  assign load   = (state_q == sgm_pkg::ST_LOAD) && (!out_valid_q || m_axis_tready_i);

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (sgm_pkg::sgm_reg_e'(paddr[2]))
      sgm_pkg::REG_FRAME_WIDTH:  prdata = sgm_pkg::ApbDw'(fw_q);
      sgm_pkg::REG_FRAME_HEIGHT: prdata = sgm_pkg::ApbDw'(fh_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= sgm_pkg::FwReset;
      fh_q <= sgm_pkg::FhReset;
    end else if (cfg_wr) begin
      unique case (sgm_pkg::sgm_reg_e'(paddr[2]))
        sgm_pkg::REG_FRAME_WIDTH:  fw_q <= pwdata[sgm_pkg::FwW-1:0];
        sgm_pkg::REG_FRAME_HEIGHT: fh_q <= pwdata[sgm_pkg::FhW-1:0];
        default: ;
      endcase
    end
  end

  // Line store for the two previous rows.
  sgm_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign up_pix  = ram_rdata[2*PW-1:PW];
  assign mid_pix = ram_rdata[PW-1:0];

  // Sobel sums: right column minus left column, top row minus bottom row.
  assign gx_pos = {2'b00, up_pix} + {1'b0, mid_pix, 1'b0} + {2'b00, pix_q};
  assign gx_neg = {2'b00, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b00, win_q[2]};
  assign gy_pos = {2'b00, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b00, up_pix};
  assign gy_neg = {2'b00, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b00, pix_q};
  assign gx_win = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
  assign gy_win = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

  // Raster counters; a zero register acts as one and the limits clamp.
  assign col_nx   = WW'(col_q) + WW'(1);
  assign row_nx   = {1'b0, row_q} + sgm_pkg::FhW'(1);
  assign wrap_col = (col_nx >= WW'(fw_q)) || (col_q == CW'(MAX_WIDTH - 1));
  assign wrap_row = (row_nx >= fh_q) ||
                    (row_q == sgm_pkg::RowW'(sgm_pkg::HeightMax - 1));

  // Squaring operands.
  assign gx_ext = sgm_pkg::RadW'(gx_q);
  assign gy_ext = sgm_pkg::RadW'(gy_q);

  // One digit of the restoring square root.
  assign rem_sh = {rem_q, rad_q[sgm_pkg::RadW-1:sgm_pkg::RadW-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  assign peak_new = (root_q > peak_q) ? root_q : peak_q;

  // Sequencer next state and datapath controls.
  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    col_d          = col_q;
    row_d          = row_q;
    win_d          = win_q;
    peak_d         = peak_q;
    step_d         = step_q;
    out_valid_d    = out_valid_q;
    pix_d          = pix_q;
    gx_d           = gx_q;
    gy_d           = gy_q;
    interior_d     = interior_q;
    last_d         = last_q;
    rad_d          = rad_q;
    rem_d          = rem_q;
    root_d         = root_q;
    out_gx_d       = out_gx_q;
    out_gy_d       = out_gy_q;
    out_mag_d      = out_mag_q;
    out_peak_d     = out_peak_q;
    out_interior_d = out_interior_q;
    out_last_d     = out_last_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = col_q;
    ram_wdata      = {mid_pix, pix_q};
    s_axis_tready_o = 1'b0;

    if (m_xfer) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // Zero the line store after reset.
      sgm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + CW'(1);
        if (clr_q == CW'(MAX_WIDTH - 1)) begin
          state_d = sgm_pkg::ST_IDLE;
        end
      end
      // Take a pixel and start the line store read of its column.
      sgm_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        ram_re          = s_axis_tvalid_i;
        if (s_xfer) begin
          pix_d   = s_axis_tdata_i;
          state_d = sgm_pkg::ST_READ;
        end
      end
      // Form the window, write the column back and step the counters.
      sgm_pkg::ST_READ: begin
        ram_we     = 1'b1;
        interior_d = (row_q >= sgm_pkg::RowW'(2)) && (col_q >= CW'(2));
        gx_d       = interior_d ? gx_win : '0;
        gy_d       = interior_d ? gy_win : '0;
        last_d     = wrap_col && wrap_row;
        win_d[0]   = win_q[3];
        win_d[1]   = win_q[4];
        win_d[2]   = win_q[5];
        win_d[3]   = up_pix;
        win_d[4]   = mid_pix;
        win_d[5]   = pix_q;
        if (wrap_col) begin
          col_d = '0;
          row_d = wrap_row ? '0 : row_nx[sgm_pkg::RowW-1:0];
        end else begin
          col_d = col_nx[CW-1:0];
        end
        state_d = sgm_pkg::ST_SQUARE;
      end
      // Sum of squares into the root unit.
      sgm_pkg::ST_SQUARE: begin
        rad_d   = $unsigned(gx_ext * gx_ext) + $unsigned(gy_ext * gy_ext);
        rem_d   = '0;
        root_d  = '0;
        step_d  = '0;
        state_d = sgm_pkg::ST_ROOT;
      end
      // One result bit per cycle.
      sgm_pkg::ST_ROOT: begin
        rad_d  = {rad_q[sgm_pkg::RadW-3:0], 2'b00};
        rem_d  = fits ? diff[sgm_pkg::RemW-1:0] : rem_sh[sgm_pkg::RemW-1:0];
        root_d = {root_q[sgm_pkg::MagW-2:0], fits};
        step_d = step_q + sgm_pkg::StepW'(1);
        if (step_q == sgm_pkg::StepW'(sgm_pkg::RootSteps - 1)) begin
          state_d = sgm_pkg::ST_LOAD;
        end
      end
      // Move the result into the output register once it is free.
      sgm_pkg::ST_LOAD: begin
        if (load) begin
          out_valid_d    = 1'b1;
          out_gx_d       = gx_q;
          out_gy_d       = gy_q;
          out_mag_d      = root_q;
          out_peak_d     = peak_new;
          out_interior_d = interior_q;
          out_last_d     = last_q;
          peak_d         = last_q ? '0 : peak_new;
          state_d        = sgm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sgm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sgm_pkg::ST_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      peak_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      peak_q      <= peak_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    pix_q          <= pix_d;
    gx_q           <= gx_d;
    gy_q           <= gy_d;
    interior_q     <= interior_d;
    last_q         <= last_d;
    rad_q          <= rad_d;
    rem_q          <= rem_d;
    root_q         <= root_d;
    out_gx_q       <= out_gx_d;
    out_gy_q       <= out_gy_d;
    out_mag_q      <= out_mag_d;
    out_peak_q     <= out_peak_d;
    out_interior_q <= out_interior_d;
    out_last_q     <= out_last_d;
  end

  // Result stream.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_peak_q, out_mag_q, out_gy_q, out_gx_q};
  assign m_axis_tuser_o  = out_interior_q;
  assign m_axis_tlast_o  = out_last_q;

  // Checks.
  `SGM_ASSERT_IMP(a_peak_covers_mag, clk_i, rst_ni, out_valid_q, out_peak_q >= out_mag_q, "frame peak below magnitude")
  `SGM_ASSERT_IMP(a_border_zero, clk_i, rst_ni, out_valid_q && !out_interior_q, (out_gx_q == '0) && (out_gy_q == '0) && (out_mag_q == '0), "border result not zero")
  `SGM_ASSERT_NXT(a_peak_clears, clk_i, rst_ni, load && last_q, peak_q == '0, "peak not cleared at frame end")
  `SGM_ASSERT_IMP(a_root_steps, clk_i, rst_ni, state_q == sgm_pkg::ST_ROOT, step_q < sgm_pkg::StepW'(sgm_pkg::RootSteps), "root step count overrun")

endmodule

`default_nettype wire

### design/sgm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### test/sgm_result_checker.sv
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: result checker
// Watches the pixel, result and configuration channels of the block. Each
// accepted pixel runs through a local model of the line stores, the 3x3
// window, the counters and the frame peak. The expected result is queued and
// compared field by field with the next result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgm_result_checker #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Pixel channel.
  input  logic                         pix_valid_i,
  input  logic                         pix_ready_i,
  input  logic [sgm_pkg::PixW-1:0]     pix_data_i,    // [7:0] pixel
  // Result channel.
  input  logic                         res_valid_i,
  input  logic                         res_ready_i,
  // [10:0] grad_x, [21:11] grad_y, [32:22] magnitude, [43:33] frame_peak
  input  logic [sgm_pkg::OutW-1:0]     res_data_i,
  input  logic                         res_user_i,    // [0] interior
  input  logic                         res_last_i,    // frame_last
  // Configuration port.
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [sgm_pkg::ApbAw-1:0]    paddr_i,
  input  logic [sgm_pkg::ApbDw-1:0]    pwdata_i,
  input  logic                         pready_i,
  // Status for the testbench top.
  output int                           failures_o,
  output int                           results_owed_o,
  output int                           results_seen_o,
  output int                           interior_seen_o
);

  import sgm_pkg::*;

  typedef struct packed {
    logic signed [GradW-1:0] grad_x;
    logic signed [GradW-1:0] grad_y;
    logic [MagW-1:0]         magnitude;
    logic                    interior;
    logic [MagW-1:0]         frame_peak;
    logic                    frame_last;
  } sobel_result_t;

  // Local copy of the block's state and configuration.
  logic [PixW-1:0] upper_row  [MAX_WIDTH];
  logic [PixW-1:0] middle_row [MAX_WIDTH];
  logic [PixW-1:0] window_px  [6];  // [0..2] column col-2, [3..5] column col-1
  int unsigned     col_pos;
  int unsigned     row_pos;
  logic [MagW-1:0] peak_so_far;
  logic [FwW-1:0]  width_reg;
  logic [FhW-1:0]  height_reg;

  sobel_result_t   pending_results [$];
  int              fail_cnt;
  int              seen_cnt;
  int              interior_cnt;

  // Integer floor square root, one result bit per step from the top down.
  function automatic logic [MagW-1:0] floor_root(input int unsigned radicand);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = MagW - 1; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root[MagW-1:0];
  endfunction

  // Advances the local state by one pixel and returns the result it causes.
  task automatic sobel_window_step(input logic [PixW-1:0] pix, output sobel_result_t res);
    int unsigned w_eff;
    int unsigned h_eff;
    int          win [3][3];
    int          gx;
    int          gy;
    logic [PixW-1:0] up;
    logic [PixW-1:0] mid;
    w_eff = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h_eff = (height_reg == 0) ? 1 : ((height_reg > HeightMax) ? HeightMax : height_reg);
    up  = '0;
    mid = '0;
    if (col_pos < MAX_WIDTH) begin
      up  = upper_row[col_pos];
      mid = middle_row[col_pos];
      upper_row[col_pos]  = mid;
      middle_row[col_pos] = pix;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = window_px[i];
      win[i][1] = window_px[3+i];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = pix;
    for (int i = 0; i < 3; i++) window_px[i] = window_px[3+i];
    window_px[3] = up;
    window_px[4] = mid;
    window_px[5] = pix;

    // The window is only complete from row 2, column 2 on; borders give zero.
    res = '0;
    res.interior = (row_pos >= 2) && (col_pos >= 2);
    if (res.interior) begin
      gx = -win[0][0] + win[0][2] - 2 * win[1][0] + 2 * win[1][2] - win[2][0] + win[2][2];
      gy = win[0][0] + 2 * win[0][1] + win[0][2] - win[2][0] - 2 * win[2][1] - win[2][2];
      res.grad_x    = gx[GradW-1:0];
      res.grad_y    = gy[GradW-1:0];
      res.magnitude = floor_root(gx * gx + gy * gy);
    end
    if (res.magnitude > peak_so_far) peak_so_far = res.magnitude;
    res.frame_peak = peak_so_far;
    res.frame_last = (col_pos + 1 >= w_eff) && (row_pos + 1 >= h_eff);

    // Raster counters; the frame peak starts over after the final pixel.
    if (col_pos + 1 >= w_eff) begin
      col_pos = 0;
      if (row_pos + 1 >= h_eff) begin
        row_pos     = 0;
        peak_so_far = '0;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  // Register writes, pixel predictions and result comparisons.
  always @(posedge clk_i or negedge rst_ni) begin
    sobel_result_t expected;
    sobel_result_t actual;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      for (int i = 0; i < 6; i++) window_px[i] = '0;
      col_pos      = 0;
      row_pos      = 0;
      peak_so_far  = '0;
      width_reg    = FwReset;
      height_reg   = FhReset;
      pending_results.delete();
      fail_cnt     = 0;
      seen_cnt     = 0;
      interior_cnt = 0;
      failures_o      <= 0;
      results_owed_o  <= 0;
      results_seen_o  <= 0;
      interior_seen_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (sgm_reg_e'(paddr_i[2]))
          REG_FRAME_WIDTH:  width_reg  = pwdata_i[FwW-1:0];
          REG_FRAME_HEIGHT: height_reg = pwdata_i[FhW-1:0];
          default: ;
        endcase
      end

      if (pix_valid_i && pix_ready_i) begin
        sobel_window_step(pix_data_i, expected);
        pending_results.push_back(expected);
      end

      if (res_valid_i && res_ready_i) begin
        actual.grad_x     = res_data_i[GradW-1:0];
        actual.grad_y     = res_data_i[2*GradW-1:GradW];
        actual.magnitude  = res_data_i[2*GradW+MagW-1:2*GradW];
        actual.frame_peak = res_data_i[2*GradW+2*MagW-1:2*GradW+MagW];
        actual.interior   = res_user_i;
        actual.frame_last = res_last_i;
        seen_cnt++;
        if (actual.interior) interior_cnt++;
        if (pending_results.size() == 0) begin
          $error("result transfer with no pixel waiting for it");
          fail_cnt++;
        end else begin
          expected = pending_results.pop_front();
          compare_field("grad_x", $signed(expected.grad_x), $signed(actual.grad_x));
          compare_field("grad_y", $signed(expected.grad_y), $signed(actual.grad_y));
          compare_field("magnitude", expected.magnitude, actual.magnitude);
          compare_field("interior", expected.interior, actual.interior);
          compare_field("frame_peak", expected.frame_peak, actual.frame_peak);
          compare_field("frame_last", expected.frame_last, actual.frame_last);
        end
      end

      failures_o      <= fail_cnt;
      results_owed_o  <= pending_results.size();
      results_seen_o  <= seen_cnt;
      interior_seen_o <= interior_cnt;
    end
  end

endmodule

### test/sobel_gradient_magnitude_tb.sv
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: testbench top
// Drives pixel frames and frame size settings into the block, stalls the
// result stream at random and leaves all prediction and comparison to the
// result checker. Covers pure edge patterns, degenerate and clamped frame
// sizes, size changes in the middle of a frame, many small random frames and
// width and height settings beyond the supported limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_gradient_magnitude_tb;

  import sgm_pkg::*;

  localparam int unsigned MAX_WIDTH = 1024;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [PixW-1:0]     s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutW-1:0]     m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [ApbAw-1:0]    paddr           = '0;
  logic [ApbDw-1:0]    pwdata          = '0;
  logic [ApbDw-1:0]    prdata;
  logic                pready;

  int failures;
  int results_owed;
  int results_seen;
  int interior_seen;

  bit quiet          = 1'b0;  // no idling on either side
  int pixels_sent    = 0;
  int random_sent    = 0;
  int size_settings  = 0;

  sobel_gradient_magnitude #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  sgm_result_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pix_valid_i     (s_axis_tvalid_i),
    .pix_ready_i     (s_axis_tready_o),
    .pix_data_i      (s_axis_tdata_i),
    .res_valid_i     (m_axis_tvalid_o),
    .res_ready_i     (m_axis_tready_i),
    .res_data_i      (m_axis_tdata_o),
    .res_user_i      (m_axis_tuser_o),
    .res_last_i      (m_axis_tlast_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .failures_o      (failures),
    .results_owed_o  (results_owed),
    .results_seen_o  (results_seen),
    .interior_seen_o (interior_seen)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result receiver: ready, broken up by random stalls.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left = 0;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // One APB write: setup, access until pready, then idle.
  task automatic apb_write(input sgm_reg_e idx, input logic [ApbDw-1:0] value);
    logic [ApbAw-1:0] addr;
    addr = ApbAw'(4 * idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sets the frame size; unused upper data bits sometimes carry noise.
  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    logic [ApbDw-1:0] w_word;
    logic [ApbDw-1:0] h_word;
    w_word = w;
    h_word = h;
    if ($urandom_range(0, 1) == 1) begin
      w_word = ($urandom & ~32'h7FF) | w_word;
      h_word = ($urandom & ~32'h1FFF) | h_word;
    end
    apb_write(REG_FRAME_WIDTH, w_word);
    apb_write(REG_FRAME_HEIGHT, h_word);
    size_settings++;
  endtask

  // One pixel transfer, sometimes after a random gap.
  task automatic send_pixel(input logic [PixW-1:0] pix);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pix;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pixels_sent++;
  endtask

  // Ends a burst and holds off until every result has arrived.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
  endtask

  function automatic logic [PixW-1:0] pick_pixel(input bit edgy);
    if (edgy) return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Sends n pixels under a new frame size; results are drained afterwards.
  task automatic run_frames(input int unsigned w, input int unsigned h, input int unsigned n);
    bit edgy;
    edgy = ($urandom_range(0, 3) == 0);
    set_frame_size(w, h);
    for (int unsigned i = 0; i < n; i++) send_pixel(pick_pixel(edgy));
    drain_results();
  endtask

  // Small random frames; now and then a frame is cut off and the next size
  // takes over in the middle of it.
  task automatic random_phase();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    case ($urandom_range(0, 9))
      0:       w = $urandom_range(1, 2);
      1:       w = $urandom_range(9, 24);
      default: w = $urandom_range(3, 8);
    endcase
    h = $urandom_range(1, 6);
    n = w * h * $urandom_range(1, 2);
    if ($urandom_range(0, 5) == 0) n = $urandom_range(1, w * h);
    run_frames(w, h, n);
    random_sent += n;
  endtask

  // Directed 3x3 frames: vertical and horizontal edges of full swing.
  logic [PixW-1:0] rising_right [9] = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
                                        8'h00, 8'h00, 8'hFF};
  logic [PixW-1:0] rising_down  [9] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        8'hFF, 8'hFF, 8'hFF};

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-swing edges in the smallest frame with an interior pixel.
    set_frame_size(3, 3);
    foreach (rising_right[i]) send_pixel(rising_right[i]);
    foreach (rising_down[i]) send_pixel(rising_down[i]);
    drain_results();

    // Zero width and height act as one: every pixel ends a frame.
    run_frames(0, 0, 3);

    // Size shrinks in the middle of a frame; the frame ends at the next test.
    run_frames(5, 4, 7);
    run_frames(3, 2, 3);

    // Random frames with idling on both sides.
    while (random_sent < 400) random_phase();

    // Width and height settings above the supported limits.
    run_frames(2047, 2, 12);
    run_frames(1, 8191, 12);

    // Closing stretch at full rate.
    quiet = 1'b1;
    while (random_sent < 460) random_phase();
    drain_results();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d pixels over %0d frame size settings.", pixels_sent, size_settings);
    $display("Checked %0d results, %0d of them with a full window.",
             results_seen, interior_seen);
    if (failures == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
